// ===== hdl/bqd_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad coefficient designer package
// Shared widths, fixed-point constants, opcodes and payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package bqd_pkg;

  // Width of every frequency field and of the sample rate register.
  localparam int FREQ_BITS = 20;
  // Default number of fraction bits in the coefficients.
  localparam int COEF_FRAC_BITS_DEF = 28;
  localparam int COEF_W = 32;

  localparam logic [FREQ_BITS-1:0] FS_RESET = FREQ_BITS'(48000);

  // Filter types.
  localparam logic [1:0] OP_LOW_PASS  = 2'd0;
  localparam logic [1:0] OP_HIGH_PASS = 2'd1;
  localparam logic [1:0] OP_BAND_PASS = 2'd2;
  // The remaining code selects no filter and is always flagged invalid.
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  // Phase and angle formats: phase in turns with 32 fraction bits, angle Q30.
  localparam int PHASE_W = 32;
  localparam int FRAC_Q  = 30;
  localparam int V_W     = 30;
  localparam int X_W     = 30;
  localparam int T_W     = 31;
  localparam int ACC_W   = 33;
  localparam int S_W     = 31;
  localparam int SERIES_TERMS = 7;

  localparam logic [PHASE_W-1:0] PH_QUARTER = 32'h4000_0000;
  localparam logic [PHASE_W-1:0] PH_EIGHTH  = 32'h2000_0000;
  localparam logic [31:0]        PI_Q30     = 32'hC90F_DAA2;
  localparam logic [T_W-1:0]     ONE_Q30    = 31'h4000_0000;

  // Alpha for low and high pass is sin(w0) * 1000 / 1414.
  localparam int ALPHA_LP_MUL = 1000;
  localparam int ALPHA_LP_DIV = 1414;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [FREQ_BITS-1:0] corner_frequency_hz;
    logic [FREQ_BITS-1:0] bandwidth_hz;
  } req_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_b0;
    logic signed [COEF_W-1:0] coef_b1;
    logic signed [COEF_W-1:0] coef_b2;
    logic signed [COEF_W-1:0] coef_a1;
    logic signed [COEF_W-1:0] coef_a2;
    logic                     invalid;
  } res_t;

  // State handed from one series cell to the next.
  typedef struct packed {
    logic [X_W-1:0]          x2;
    logic [T_W-1:0]          ts;
    logic [T_W-1:0]          tc;
    logic signed [ACC_W-1:0] acc_s;
    logic signed [ACC_W-1:0] acc_c;
  } series_t;

endpackage

`default_nettype wire

// ===== hdl/biquad_coefficient_designer.sv =====
// ----------------------------------------------------------------------------
// Biquad coefficient designer
// The pipeline depth is set by the phase, alpha and coefficient divider rows and
// the seven series cells.
// Throughput: one request per cycle; the whole pipeline holds while a result
// is stalled. Reset clears all valid bits and sets the sample rate to 48000.
// ----------------------------------------------------------------------------
`default_nettype none

module biquad_coefficient_designer #(
  parameter int COEF_FRAC_BITS = bqd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire bqd_pkg::req_t                 req_data,
  output logic                               res_valid,
  input  wire logic                          res_stall,
  output bqd_pkg::res_t                      res_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bqd_pkg::FREQ_BITS-1:0] cfg_data
);

  import bqd_pkg::*;

  localparam int FB       = FREQ_BITS;
  localparam int NUMA_W   = S_W + FB;
  localparam int ALPHA_QW = 29 + FB;
  localparam int ADW      = FB + 1;
  localparam int AW       = FB + 31;
  localparam int DRW      = AW + 2;
  localparam int CQW      = COEF_FRAC_BITS + 2;
  localparam int NRW      = DRW + CQW;
  localparam int NDIV     = 4;
  localparam int DIV_B0   = 0;
  localparam int DIV_B1   = 1;
  localparam int DIV_A1   = 2;
  localparam int DIV_A2   = 3;

  typedef struct packed {
    logic [1:0]    op;
    logic [FB-1:0] f;
    logic [FB-1:0] bw;
    logic          bad;
  } front_t;

  typedef struct packed {
    logic   quad;
    logic   oct;
    front_t fr;
  } angle_t;

  typedef struct packed {
    logic [1:0]              op;
    logic                    bad;
    logic [S_W-1:0]          s;
    logic signed [ACC_W-1:0] c;
  } mid_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad;
    logic       neg_a1;
  } tail_t;

  logic en;
  logic [FB-1:0] fs;

  // The pipeline moves unless a finished result is held by the receiver.
  assign en        = !(res_valid && res_stall);
  assign req_stall = !en;
  assign cfg_ready = 1'b1;

  // Sample rate register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fs <= FS_RESET;
    end else if (cfg_valid) begin
      fs <= cfg_data;
    end
  end

  // Request register and range checks.
  logic          s0_valid;
  front_t        s0_fr;
  logic [FB-1:0] s0_fs;
  logic          bad_w;

  always_comb begin
    bad_w = (req_data.opcode != OP_LOW_PASS && req_data.opcode != OP_HIGH_PASS &&
             req_data.opcode != OP_BAND_PASS) ||
            (req_data.corner_frequency_hz == '0) ||
            ({req_data.corner_frequency_hz, 1'b0} >= {1'b0, fs}) ||
            (req_data.opcode == OP_BAND_PASS && req_data.bandwidth_hz == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_fr.op  <= req_data.opcode;
      s0_fr.f   <= req_data.corner_frequency_hz;
      s0_fr.bw  <= req_data.bandwidth_hz;
      s0_fr.bad <= bad_w;
      s0_fs     <= fs;
    end
  end

  // Phase p = f * 2^32 / fs.
  logic [PHASE_W-1:0] p_q;
  logic               ph_valid;
  front_t             ph_fr;

  bqd_divider #(.DW(FB), .QW(PHASE_W)) u_phase_div (
    .clk    (clk),
    .en     (en),
    .num_hi (s0_fr.f),
    .num_lo ('0),
    .den    (s0_fs),
    .quot   (p_q)
  );

  bqd_delay #(.DEPTH(PHASE_W), .W($bits(front_t))) u_phase_dly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (s0_valid),
    .data      (s0_fr),
    .dly_valid (ph_valid),
    .dly_data  (ph_fr)
  );

  // Octant reduction and conversion of turns to radians.
  logic               quad_w;
  logic               oct_w;
  logic [PHASE_W-1:0] u_w;
  logic [PHASE_W-1:0] vfull_w;
  logic [V_W+31:0]    xprod_w;
  logic               s1_valid;
  angle_t             s1_ang;
  logic [X_W-1:0]     s1_x;

  always_comb begin
    quad_w  = p_q >= PH_QUARTER;
    u_w     = quad_w ? p_q - PH_QUARTER : p_q;
    oct_w   = u_w > PH_EIGHTH;
    vfull_w = oct_w ? PH_QUARTER - u_w : u_w;
    xprod_w = (V_W + 32)'(vfull_w[V_W-1:0]) * (V_W + 32)'(PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= ph_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ang.quad <= quad_w;
      s1_ang.oct  <= oct_w;
      s1_ang.fr   <= ph_fr;
      s1_x        <= xprod_w[31 +: X_W];
    end
  end

  // Square of the angle and the first series terms.
  logic [2*X_W-1:0] xx_w;
  logic             s2_valid;
  angle_t           s2_ang;
  series_t          ser_c [SERIES_TERMS+1];

  assign xx_w = (2 * X_W)'(s1_x) * (2 * X_W)'(s1_x);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_ang          <= s1_ang;
      ser_c[0].x2     <= xx_w[FRAC_Q +: X_W];
      ser_c[0].ts     <= T_W'(s1_x);
      ser_c[0].tc     <= ONE_Q30;
      ser_c[0].acc_s  <= $signed(ACC_W'(s1_x));
      ser_c[0].acc_c  <= $signed(ACC_W'(ONE_Q30));
    end
  end

  // Row of series cells.
  for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_series
    bqd_series_cell #(.K(k + 1)) u_cell (
      .clk  (clk),
      .en   (en),
      .prev (ser_c[k]),
      .term (ser_c[k+1])
    );
  end

  logic   sr_valid;
  angle_t sr_ang;

  bqd_delay #(.DEPTH(3 * SERIES_TERMS), .W($bits(angle_t))) u_series_dly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (s2_valid),
    .data      (s2_ang),
    .dly_valid (sr_valid),
    .dly_data  (sr_ang)
  );

  // Undo the octant and quadrant folding; sine is clamped at zero.
  logic signed [ACC_W-1:0] ss_w;
  logic signed [ACC_W-1:0] cc_w;
  logic signed [ACC_W-1:0] sv_w;
  logic signed [ACC_W-1:0] cv_w;
  logic                    s3_valid;
  front_t                  s3_fr;
  logic [S_W-1:0]          s3_s;
  logic signed [ACC_W-1:0] s3_c;

  always_comb begin
    ss_w = sr_ang.oct ? ser_c[SERIES_TERMS].acc_c : ser_c[SERIES_TERMS].acc_s;
    cc_w = sr_ang.oct ? ser_c[SERIES_TERMS].acc_s : ser_c[SERIES_TERMS].acc_c;
    sv_w = sr_ang.quad ? cc_w : ss_w;
    cv_w = sr_ang.quad ? -ss_w : cc_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= sr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_fr <= sr_ang.fr;
      s3_s  <= (sv_w < 0) ? '0 : sv_w[S_W-1:0];
      s3_c  <= cv_w;
    end
  end

  // Alpha numerator and divisor.
  logic [FB-1:0]     amul_w;
  logic [ADW-1:0]    aden_w;
  logic              s4_valid;
  mid_t              s4_mid;
  logic [NUMA_W-1:0] s4_num;
  logic [ADW-1:0]    s4_den;

  always_comb begin
    if (s3_fr.op == OP_BAND_PASS) begin
      amul_w = s3_fr.bw;
      aden_w = {s3_fr.f, 1'b0};
    end else begin
      amul_w = FB'(ALPHA_LP_MUL);
      aden_w = ADW'(ALPHA_LP_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_mid.op  <= s3_fr.op;
      s4_mid.bad <= s3_fr.bad;
      s4_mid.s   <= s3_s;
      s4_mid.c   <= s3_c;
      s4_num     <= NUMA_W'(s3_s) * NUMA_W'(amul_w);
      s4_den     <= aden_w;
    end
  end

  // Alpha division.
  logic [ALPHA_QW-1:0] alpha_q;
  logic                al_valid;
  mid_t                al_mid;

  bqd_divider #(.DW(ADW), .QW(ALPHA_QW)) u_alpha_div (
    .clk    (clk),
    .en     (en),
    .num_hi (ADW'(s4_num[NUMA_W-1:ALPHA_QW])),
    .num_lo (s4_num[ALPHA_QW-1:0]),
    .den    (s4_den),
    .quot   (alpha_q)
  );

  bqd_delay #(.DEPTH(ALPHA_QW), .W($bits(mid_t))) u_alpha_dly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (s4_valid),
    .data      (s4_mid),
    .dly_valid (al_valid),
    .dly_data  (al_mid)
  );

  // a0 = 1 + alpha.
  logic          s5_valid;
  mid_t          s5_mid;
  logic [AW-1:0] s5_a0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= al_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_mid <= al_mid;
      s5_a0  <= AW'(alpha_q) + AW'(ONE_Q30);
    end
  end

  // Rounded division operands: (2 * |num| * 2^F + d) / (2 * d).
  logic signed [ACC_W-1:0] onec_m_w;
  logic signed [ACC_W-1:0] onec_p_w;
  logic signed [ACC_W-1:0] c2_w;
  logic [31:0]             mag0_w;
  logic [31:0]             mag1_w;
  logic [31:0]             mag3_w;
  logic [AW:0]             d0_w;
  logic                    s6_valid;
  tail_t                   s6_tail;
  logic [NRW-1:0]          s6_nr [NDIV];
  logic [DRW-1:0]          s6_dr [NDIV];

  always_comb begin
    onec_m_w = $signed(ACC_W'(ONE_Q30)) - s5_mid.c;
    onec_p_w = $signed(ACC_W'(ONE_Q30)) + s5_mid.c;
    c2_w     = s5_mid.c <<< 1;
    mag3_w   = (c2_w < 0) ? 32'(-c2_w) : 32'(c2_w);
    d0_w     = {s5_a0, 1'b0};
    mag0_w   = 32'(s5_mid.s);
    mag1_w   = 32'(onec_m_w);
    unique case (s5_mid.op)
      OP_LOW_PASS: begin
        mag0_w = 32'(onec_m_w);
        mag1_w = 32'(onec_m_w);
      end
      OP_HIGH_PASS: begin
        mag0_w = 32'(onec_p_w);
        mag1_w = 32'(onec_p_w);
      end
      default: begin
        mag0_w = 32'(s5_mid.s);
        mag1_w = 32'(onec_m_w);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_tail.op     <= s5_mid.op;
      s6_tail.bad    <= s5_mid.bad;
      s6_tail.neg_a1 <= s5_mid.c > 0;
      s6_nr[DIV_B0]  <= (NRW'(mag0_w) << (COEF_FRAC_BITS + 1)) + NRW'(d0_w);
      s6_dr[DIV_B0]  <= {DRW'(d0_w)} << 1;
      s6_nr[DIV_B1]  <= (NRW'(mag1_w) << (COEF_FRAC_BITS + 1)) + NRW'(s5_a0);
      s6_dr[DIV_B1]  <= {DRW'(s5_a0)} << 1;
      s6_nr[DIV_A1]  <= (NRW'(mag3_w) << (COEF_FRAC_BITS + 1)) + NRW'(s5_a0);
      s6_dr[DIV_A1]  <= {DRW'(s5_a0)} << 1;
      s6_nr[DIV_A2]  <= (NRW'(1) << (32 + COEF_FRAC_BITS)) + NRW'(s5_a0);
      s6_dr[DIV_A2]  <= {DRW'(s5_a0)} << 1;
    end
  end

  // Coefficient dividers.
  logic [CQW-1:0] cq [NDIV];
  logic           tl_valid;
  tail_t          tl_tail;

  for (genvar i = 0; i < NDIV; i++) begin : g_coef_div
    bqd_divider #(.DW(DRW), .QW(CQW)) u_div (
      .clk    (clk),
      .en     (en),
      .num_hi (s6_nr[i][NRW-1:CQW]),
      .num_lo (s6_nr[i][CQW-1:0]),
      .den    (s6_dr[i]),
      .quot   (cq[i])
    );
  end

  bqd_delay #(.DEPTH(CQW), .W($bits(tail_t))) u_coef_dly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .valid     (s6_valid),
    .data      (s6_tail),
    .dly_valid (tl_valid),
    .dly_data  (tl_tail)
  );

  // Apply signs and build the result.
  logic signed [COEF_W-1:0] qv [NDIV];
  res_t                     res_w;

  always_comb begin
    for (int i = 0; i < NDIV; i++) begin
      qv[i] = $signed(COEF_W'(cq[i]));
    end
    res_w.invalid = 1'b0;
    res_w.coef_b0 = qv[DIV_B0];
    res_w.coef_b2 = qv[DIV_B0];
    res_w.coef_b1 = qv[DIV_B1];
    res_w.coef_a1 = tl_tail.neg_a1 ? -qv[DIV_A1] : qv[DIV_A1];
    res_w.coef_a2 = qv[DIV_A2] - $signed(COEF_W'(1) << COEF_FRAC_BITS);
    unique case (tl_tail.op)
      OP_HIGH_PASS: begin
        res_w.coef_b1 = -qv[DIV_B1];
      end
      OP_BAND_PASS: begin
        res_w.coef_b1 = '0;
        res_w.coef_b2 = -qv[DIV_B0];
      end
      default: begin
        res_w.coef_b1 = qv[DIV_B1];
      end
    endcase
    if (tl_tail.bad) begin
      res_w = '0;
      res_w.invalid = 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= tl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_data <= res_w;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqd_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring step: shifts in one dividend bit and retires one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_div_cell #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] prev_rem,
  input  wire logic [QW-1:0] prev_lq,
  input  wire logic [DW-1:0] prev_den,
  output logic      [DW-1:0] rem,
  output logic      [QW-1:0] lq,
  output logic      [DW-1:0] den
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        ge;

  // Partial remainder stays below the divisor, so the trial fits DW+1 bits.
  always_comb begin
    trial = {prev_rem, prev_lq[QW-1]};
    diff  = trial - {1'b0, prev_den};
    ge    = trial >= {1'b0, prev_den};
  end

  // Low dividend bits shift out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (en) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      lq  <= {prev_lq[QW-2:0], ge};
      den <= prev_den;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqd_divider.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider
// A row of divider cells, one quotient bit per cell, one division per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_divider #(
  parameter int DW = 8,
  parameter int QW = 8
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] num_hi,
  input  wire logic [QW-1:0] num_lo,
  input  wire logic [DW-1:0] den,
  output logic      [QW-1:0] quot
);

  logic [DW-1:0] rem_c [QW+1];
  logic [QW-1:0] lq_c  [QW+1];
  logic [DW-1:0] den_c [QW+1];

  assign rem_c[0] = num_hi;
  assign lq_c[0]  = num_lo;
  assign den_c[0] = den;

  // Chain of cells; after the last one the shift register holds the quotient.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    bqd_div_cell #(.DW(DW), .QW(QW)) u_cell (
      .clk      (clk),
      .en       (en),
      .prev_rem (rem_c[i]),
      .prev_lq  (lq_c[i]),
      .prev_den (den_c[i]),
      .rem      (rem_c[i+1]),
      .lq       (lq_c[i+1]),
      .den      (den_c[i+1])
    );
  end

  assign quot = lq_c[QW];

endmodule

`default_nettype wire

// ===== hdl/bqd_series_cell.sv =====
// ----------------------------------------------------------------------------
// Sine and cosine series cell
// Computes the next Taylor term of both series and adds it with its sign.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_series_cell #(
  parameter int K = 1
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire bqd_pkg::series_t prev,
  output bqd_pkg::series_t      term
);

  import bqd_pkg::*;

  localparam int MW = T_W + X_W;
  localparam int PW = T_W + 32;
  localparam int D_S = 2 * K * (2 * K + 1);
  localparam int D_C = (2 * K - 1) * 2 * K;
  localparam logic [31:0] R_S  = 32'((64'd1 << 32) / D_S);
  localparam logic [31:0] R_C  = 32'((64'd1 << 32) / D_C);
  localparam logic [31:0] DS32 = 32'(D_S);
  localparam logic [31:0] DC32 = 32'(D_C);

  logic [MW-1:0]           a_ms;
  logic [MW-1:0]           a_mc;
  logic [X_W-1:0]          a_x2;
  logic signed [ACC_W-1:0] a_acc_s;
  logic signed [ACC_W-1:0] a_acc_c;

  logic [T_W-1:0]          b_as;
  logic [T_W-1:0]          b_ac;
  logic [PW-1:0]           b_ps;
  logic [PW-1:0]           b_pc;
  logic [X_W-1:0]          b_x2;
  logic signed [ACC_W-1:0] b_acc_s;
  logic signed [ACC_W-1:0] b_acc_c;

  logic [T_W-1:0] as_w;
  logic [T_W-1:0] ac_w;
  logic [T_W-1:0] q0s;
  logic [T_W-1:0] q0c;
  logic [31:0]    rs;
  logic [31:0]    rc;
  logic [T_W-1:0] qs;
  logic [T_W-1:0] qc;

  // Term times x squared.
  always_ff @(posedge clk) begin
    if (en) begin
      a_ms    <= MW'(prev.ts) * MW'(prev.x2);
      a_mc    <= MW'(prev.tc) * MW'(prev.x2);
      a_x2    <= prev.x2;
      a_acc_s <= prev.acc_s;
      a_acc_c <= prev.acc_c;
    end
  end

  // Back to Q30, then multiply by the reciprocal of the term divisor.
  assign as_w = a_ms[FRAC_Q +: T_W];
  assign ac_w = a_mc[FRAC_Q +: T_W];

  always_ff @(posedge clk) begin
    if (en) begin
      b_as    <= as_w;
      b_ac    <= ac_w;
      b_ps    <= PW'(as_w) * PW'(R_S);
      b_pc    <= PW'(ac_w) * PW'(R_C);
      b_x2    <= a_x2;
      b_acc_s <= a_acc_s;
      b_acc_c <= a_acc_c;
    end
  end

  // The reciprocal estimate is low by at most one; one compare corrects it.
  always_comb begin
    q0s = b_ps[32 +: T_W];
    q0c = b_pc[32 +: T_W];
    rs  = 32'(b_as) - 32'(q0s) * DS32;
    rc  = 32'(b_ac) - 32'(q0c) * DC32;
    qs  = q0s + T_W'(rs >= DS32);
    qc  = q0c + T_W'(rc >= DC32);
  end

  // Odd terms subtract, even terms add.
  always_ff @(posedge clk) begin
    if (en) begin
      term.x2 <= b_x2;
      term.ts <= qs;
      term.tc <= qc;
      if (K % 2 == 1) begin
        term.acc_s <= b_acc_s - $signed(ACC_W'(qs));
        term.acc_c <= b_acc_c - $signed(ACC_W'(qc));
      end else begin
        term.acc_s <= b_acc_s + $signed(ACC_W'(qs));
        term.acc_c <= b_acc_c + $signed(ACC_W'(qc));
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bqd_delay.sv =====
// ----------------------------------------------------------------------------
// Context delay line
// Carries the valid bit and request context alongside a pipelined unit.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_delay #(
  parameter int DEPTH = 2,
  parameter int W     = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         valid,
  input  wire logic [W-1:0] data,
  output logic              dly_valid,
  output logic      [W-1:0] dly_data
);

  logic [DEPTH-1:0] vld;
  logic [W-1:0]     dat [DEPTH];

  // Valid bits clear on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld[0] <= valid;
      for (int i = 1; i < DEPTH; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  // Context taps.
  always_ff @(posedge clk) begin
    if (en) begin
      dat[0] <= data;
      for (int i = 1; i < DEPTH; i++) begin
        dat[i] <= dat[i-1];
      end
    end
  end

  assign dly_valid = vld[DEPTH-1];
  assign dly_data  = dat[DEPTH-1];

endmodule

`default_nettype wire

// ===== hdl/bqd_checker.sv =====
// ----------------------------------------------------------------------------
// Biquad coefficient designer checker
// Port-level assertions on the result channel and request flow control.
// ----------------------------------------------------------------------------
`default_nettype none

module bqd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_stall,
  input wire logic          res_valid,
  input wire logic          res_stall,
  input wire bqd_pkg::res_t res_data
);

  import bqd_pkg::*;

  // A held result keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("held result changed");

  // A held result stops new requests.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |-> req_stall)
    else $error("request taken while result held");

  // Invalid results carry zero coefficients.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.invalid |->
      res_data.coef_b0 == 0 && res_data.coef_b1 == 0 && res_data.coef_b2 == 0 &&
      res_data.coef_a1 == 0 && res_data.coef_a2 == 0)
    else $error("invalid result with nonzero coefficients");

  // Reset empties the output.
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind biquad_coefficient_designer bqd_checker u_bqd_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_data  (res_data)
);

`default_nettype wire
